>>> sv/ccbd_pkg.sv
// Shared types and constants for the center-crop box downscaler.
package ccbd_pkg;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CFG  = 2'd1;
  localparam logic [1:0] ST_BAD_COORD = 2'd2;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DST_SIZE   = 2'd2;

  localparam int unsigned MIN_DST = 4;
  localparam int unsigned MAX_SRC_DIM = 128;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPAN_X0,
    S_SPAN_X1,
    S_SPAN_Y0,
    S_SPAN_Y1,
    S_WALK,
    S_DRAIN,
    S_DIV,
    S_OUT
  } state_t;

endpackage

>>> sv/ccbd_ram.sv
// Generic single-port-write, registered-read RAM.
module ccbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/center_crop_box_downscale_rgba.sv
// Center-crop box downscaler for RGBA8 images: top level.
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets src_width,
//   src_height and dst_size; write it only while the block is idle.
//   Input transactions carry a command: a load stores one RGBA8 source pixel
//   at (src_x, src_y) and gives no result. A compute names destination pixel
//   (dst_x, dst_y) and gives one result transaction with status and four
//   averaged channels (zero on error).
// Steps of a compute, accept to out_valid: the four span divisions (25
//   quotient bits, one per cycle, in a shared restoring divider, after which
//   the quotient is taken), a walk over each source pixel of the span, a
//   drain of the last RAM read, the division of the four channel sums by
//   the pixel count, then the output. Errors go straight to the output.
// One item is worked on at a time; the next is taken the cycle after the
//   result is loaded into the output register.
//   A stalled result only blocks the next compute when it is ready to output.
// Reset returns the registers to 128, 128, 4 and empties the pipeline. The
//   pixel store is not cleared; reading an unloaded pixel gives garbage.
// A stall on the output holds the result register unchanged.
module center_crop_box_downscale_rgba #(
  parameter int MAX_DST_SIZE = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [6:0]  src_x,
  input  logic [6:0]  src_y,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  input  logic [11:0] dst_x,
  input  logic [11:0] dst_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha
);

  localparam int CW = $clog2(ccbd_pkg::MAX_SRC_DIM);
  localparam int AW = 2 * CW;
  localparam int PW = 25; // product d*side fits 12+1+8 bits with margin
  localparam int QW = 13;
  localparam int SW = 8 + 2 * 8 + 1; // channel sum over up to 128x128... capped
  localparam logic [12:0] MAXD = 13'(MAX_DST_SIZE);
  localparam logic [7:0]  MAXS = 8'(ccbd_pkg::MAX_SRC_DIM);

  logic [7:0]  src_width, src_height;
  logic [12:0] dst_size;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 8'd128;
      src_height <= 8'd128;
      dst_size   <= 13'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        ccbd_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data[7:0];
        ccbd_pkg::REG_SRC_HEIGHT: src_height <= cfg_data[7:0];
        ccbd_pkg::REG_DST_SIZE:   dst_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  ccbd_pkg::state_t state, state_next;

  logic [7:0]  side;
  logic [7:0]  offx, offy;
  assign side = (src_width < src_height) ? src_width : src_height;
  assign offx = (src_width - side) >> 1;
  assign offy = (src_height - side) >> 1;

  logic bad_cfg, bad_coord;
  assign bad_cfg = (src_width == 8'd0) || (src_height == 8'd0) || (src_width > MAXS) ||
                   (src_height > MAXS) || (dst_size < 13'(ccbd_pkg::MIN_DST)) ||
                   (dst_size > MAXD);
  assign bad_coord = ({1'b0, dst_x} >= dst_size) || ({1'b0, dst_y} >= dst_size);

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ccbd_pkg::S_IDLE);

  // pixel store
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_rdata;
  logic            ld_ok;
  logic [CW:0]     ld_x, ld_y;
  assign ld_x   = (CW + 1)'(src_x);
  assign ld_y   = (CW + 1)'(src_y);
  assign ld_ok  = (ld_x < (CW + 1)'(ccbd_pkg::MAX_SRC_DIM)) &&
                  (ld_y < (CW + 1)'(ccbd_pkg::MAX_SRC_DIM));
  assign ram_we = accept && (command == ccbd_pkg::CMD_LOAD) && ld_ok;
  assign ram_waddr = {ld_y[CW-1:0], ld_x[CW-1:0]};

  ccbd_ram #(.WIDTH(32), .DEPTH(ccbd_pkg::MAX_SRC_DIM * ccbd_pkg::MAX_SRC_DIM)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr),
    .wdata({in_alpha, in_blue, in_green, in_red}),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // shared restoring divider, one quotient bit per cycle
  logic [PW-1:0] dv_num;
  logic [PW-1:0] dv_rem;
  logic [QW-1:0] dv_den;
  logic [PW-1:0] dv_quo;
  logic [4:0]    dv_cnt;
  logic [PW:0]   dv_trial;
  assign dv_trial = {dv_rem, dv_num[PW-1]} - {{(PW+1-QW){1'b0}}, dv_den};

  logic [11:0] dx, dy;
  logic [7:0]  x0, x1, y0, xs, ys, xc, yc;
  logic [SW-1:0] acc [4];
  logic [1:0]  ch;
  logic        rd_pend;
  logic [7:0]  res [4];
  logic [1:0]  res_status;

  // address of current walk pixel: crop offset plus span position
  logic [8:0] r_row, r_col;
  assign r_row = 9'(offy) + 9'(y0) + 9'(yc);
  assign r_col = 9'(offx) + 9'(x0) + 9'(xc);
  assign ram_raddr = {r_row[CW-1:0], r_col[CW-1:0]};
  logic rd_in;
  assign rd_in = (r_row < 9'(ccbd_pkg::MAX_SRC_DIM)) && (r_col < 9'(ccbd_pkg::MAX_SRC_DIM));
  logic rd_in_q;

  logic walk_last;
  assign walk_last = (xc == xs - 8'd1) && (yc == ys - 8'd1);
  logic div_done;
  assign div_done = (dv_cnt == 5'd0);

  always_comb begin
    state_next = state;
    case (state)
      ccbd_pkg::S_IDLE:
        if (accept && command == ccbd_pkg::CMD_COMPUTE) begin
          state_next = (bad_cfg || bad_coord) ? ccbd_pkg::S_OUT : ccbd_pkg::S_SPAN_X0;
        end
      ccbd_pkg::S_SPAN_X0: if (div_done) state_next = ccbd_pkg::S_SPAN_X1;
      ccbd_pkg::S_SPAN_X1: if (div_done) state_next = ccbd_pkg::S_SPAN_Y0;
      ccbd_pkg::S_SPAN_Y0: if (div_done) state_next = ccbd_pkg::S_SPAN_Y1;
      ccbd_pkg::S_SPAN_Y1: if (div_done) state_next = ccbd_pkg::S_WALK;
      ccbd_pkg::S_WALK:    if (walk_last) state_next = ccbd_pkg::S_DRAIN;
      ccbd_pkg::S_DRAIN:   state_next = ccbd_pkg::S_DIV;
      ccbd_pkg::S_DIV:     if (div_done && ch == 2'd3) state_next = ccbd_pkg::S_OUT;
      ccbd_pkg::S_OUT:     if (!(out_valid && out_stall)) state_next = ccbd_pkg::S_IDLE;
      default: state_next = ccbd_pkg::S_IDLE;
    endcase
  end

  logic div_busy;
  always_comb begin
    div_busy = 1'b0;
    case (state)
      ccbd_pkg::S_SPAN_X0, ccbd_pkg::S_SPAN_X1, ccbd_pkg::S_SPAN_Y0,
      ccbd_pkg::S_SPAN_Y1, ccbd_pkg::S_DIV: div_busy = 1'b1;
      default: div_busy = 1'b0;
    endcase
  end

  // numerators for the four span divisions
  function automatic logic [PW-1:0] span_num(input logic [12:0] d, input logic [7:0] s);
    span_num = PW'(d) * PW'(s);
  endfunction

  logic [7:0] xlen;
  assign xlen = (x1 > x0) ? x1 - x0 : 8'd1;

  logic [15:0] count;
  assign count = xs * ys;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ccbd_pkg::S_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ccbd_pkg::S_OUT && !(out_valid && out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      rd_pend <= (state == ccbd_pkg::S_WALK);
    end
  end

  always_ff @(posedge clk) begin
    rd_in_q <= rd_in;
    // divider step
    if (div_busy && !div_done) begin
      dv_num <= {dv_num[PW-2:0], 1'b0};
      if (!dv_trial[PW]) begin
        dv_rem <= dv_trial[PW-1:0];
        dv_quo <= {dv_quo[PW-2:0], 1'b1};
      end else begin
        dv_rem <= {dv_rem[PW-2:0], dv_num[PW-1]};
        dv_quo <= {dv_quo[PW-2:0], 1'b0};
      end
      dv_cnt <= dv_cnt - 5'd1;
    end
    case (state)
      ccbd_pkg::S_IDLE: begin
        dx <= dst_x;
        dy <= dst_y;
        res_status <= bad_cfg ? ccbd_pkg::ST_BAD_CFG :
                      (bad_coord ? ccbd_pkg::ST_BAD_COORD : ccbd_pkg::ST_OK);
        for (int k = 0; k < 4; k++) res[k] <= 8'd0;
        dv_num <= span_num({1'b0, dst_x}, side);
        dv_rem <= '0;
        dv_quo <= '0;
        dv_den <= dst_size;
        dv_cnt <= 5'(PW);
      end
      ccbd_pkg::S_SPAN_X0: if (div_done) begin
        x0 <= dv_quo[7:0];
        dv_num <= span_num(13'(dx) + 13'd1, side);
        dv_rem <= '0; dv_cnt <= 5'(PW);
      end
      ccbd_pkg::S_SPAN_X1: if (div_done) begin
        x1 <= dv_quo[7:0];
        dv_num <= span_num({1'b0, dy}, side);
        dv_rem <= '0; dv_cnt <= 5'(PW);
      end
      ccbd_pkg::S_SPAN_Y0: if (div_done) begin
        y0 <= dv_quo[7:0];
        dv_num <= span_num(13'(dy) + 13'd1, side);
        dv_rem <= '0; dv_cnt <= 5'(PW);
      end
      ccbd_pkg::S_SPAN_Y1: if (div_done) begin
        xs <= xlen;
        ys <= (dv_quo[7:0] > y0) ? dv_quo[7:0] - y0 : 8'd1;
        xc <= 8'd0;
        yc <= 8'd0;
        for (int k = 0; k < 4; k++) acc[k] <= '0;
      end
      ccbd_pkg::S_WALK: begin
        if (xc == xs - 8'd1) begin
          xc <= 8'd0;
          yc <= yc + 8'd1;
        end else begin
          xc <= xc + 8'd1;
        end
      end
      ccbd_pkg::S_DRAIN: begin
        ch <= 2'd0;
        // the last span pixel lands in acc this same edge, so add it here
        dv_num <= PW'(acc[0]) + (rd_in_q ? PW'(ram_rdata[7:0]) : PW'(0));
        dv_rem <= '0;
        dv_den <= QW'(count);
        dv_cnt <= 5'(PW);
      end
      ccbd_pkg::S_DIV: if (div_done) begin
        res[ch] <= dv_quo[7:0];
        ch <= ch + 2'd1;
        dv_num <= PW'(acc[ch + 2'd1]);
        dv_rem <= '0;
        dv_cnt <= 5'(PW);
      end
      ccbd_pkg::S_OUT: begin
        if (!(out_valid && out_stall)) begin
          status    <= res_status;
          out_red   <= res[0];
          out_green <= res[1];
          out_blue  <= res[2];
          out_alpha <= res[3];
        end
      end
      default: ;
    endcase
    // accumulate data of the read issued in the previous cycle
    if (rd_pend && rd_in_q) begin
      for (int k = 0; k < 4; k++) acc[k] <= acc[k] + SW'(ram_rdata[8*k +: 8]);
    end
  end

endmodule

>>> verif/ccbd_checker.sv
// Checker for the center-crop box downscaler: predicts each compute result and compares.
`timescale 1ns / 1ps
module ccbd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        command,
  input  logic [6:0]  src_x,
  input  logic [6:0]  src_y,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  input  logic [11:0] dst_x,
  input  logic [11:0] dst_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_alpha,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int unsigned SRC_DIM = 128;
  localparam int unsigned DST_MAX = 4096;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } box_pixel_t;

  logic [31:0] pixel_store [SRC_DIM*SRC_DIM];
  logic [7:0]  width_q;
  logic [7:0]  height_q;
  logic [12:0] size_q;
  box_pixel_t  box_pixels_due [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic box_pixel_t box_average(input logic [11:0] px, input logic [11:0] py);
    box_pixel_t res;
    int unsigned side, offx, offy, x0, x1, y0, y1, xs, ys, cnt;
    int unsigned sum [4];
    logic [31:0] word;
    res = '0;
    sum = '{0, 0, 0, 0};
    if (width_q == 0 || height_q == 0 || width_q > SRC_DIM || height_q > SRC_DIM ||
        size_q < ccbd_pkg::MIN_DST || size_q > DST_MAX) begin
      res.status = ccbd_pkg::ST_BAD_CFG;
      return res;
    end
    if (px >= size_q || py >= size_q) begin
      res.status = ccbd_pkg::ST_BAD_COORD;
      return res;
    end
    side = (width_q < height_q) ? width_q : height_q;
    offx = (width_q - side) / 2;
    offy = (height_q - side) / 2;
    x0 = (px * side) / size_q;
    x1 = ((px + 1) * side) / size_q;
    y0 = (py * side) / size_q;
    y1 = ((py + 1) * side) / size_q;
    xs = (x1 > x0) ? x1 - x0 : 1;
    ys = (y1 > y0) ? y1 - y0 : 1;
    for (int unsigned r = y0; r < y0 + ys; r++)
      for (int unsigned c = x0; c < x0 + xs; c++) begin
        word = pixel_store[(offy + r) * SRC_DIM + offx + c];
        for (int k = 0; k < 4; k++) sum[k] += word[8*k +: 8];
      end
    cnt = xs * ys;
    res.status = ccbd_pkg::ST_OK;
    res.red   = 8'(sum[0] / cnt);
    res.green = 8'(sum[1] / cnt);
    res.blue  = 8'(sum[2] / cnt);
    res.alpha = 8'(sum[3] / cnt);
    return res;
  endfunction

  always @(posedge clk) begin
    box_pixel_t want;
    box_pixel_t got;
    if (rst) begin
      width_q  <= 8'd128;
      height_q <= 8'd128;
      size_q   <= 13'd4;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ccbd_pkg::REG_SRC_WIDTH:  width_q  <= cfg_data[7:0];
          ccbd_pkg::REG_SRC_HEIGHT: height_q <= cfg_data[7:0];
          ccbd_pkg::REG_DST_SIZE:   size_q   <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (command == ccbd_pkg::CMD_LOAD)
          pixel_store[src_y * SRC_DIM + src_x] = {in_alpha, in_blue, in_green, in_red};
        else
          box_pixels_due.push_back(box_average(dst_x, dst_y));
      end
      if (out_valid && !out_stall) begin
        got = '{status, out_red, out_green, out_blue, out_alpha};
        if (box_pixels_due.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, got);
          fail_count++;
        end else begin
          want = box_pixels_due.pop_front();
          if (got !== want) begin
            $display("%0t: expected st=%0d rgba=%h %h %h %h, got st=%0d rgba=%h %h %h %h",
                     $time, want.status, want.red, want.green, want.blue, want.alpha,
                     got.status, got.red, got.green, got.blue, got.alpha);
            fail_count++;
          end
        end
      end
    end
    pending = box_pixels_due.size();
  end

endmodule

>>> verif/center_crop_box_downscale_rgba_tb.sv
// Testbench top for the center-crop box downscaler: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module center_crop_box_downscale_rgba_tb;

  localparam int unsigned SRC_DIM = 128;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = ccbd_pkg::CMD_LOAD;
  logic [6:0]  src_x = '0;
  logic [6:0]  src_y = '0;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic [7:0]  in_alpha = '0;
  logic [11:0] dst_x = '0;
  logic [11:0] dst_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;

  int unsigned fail_count, pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  longint      cycles = 0;
  int unsigned n_loads = 0, n_computes = 0, n_settings = 0;

  // shadow of the setup and of which store entries hold data
  bit          loaded [SRC_DIM*SRC_DIM];
  int unsigned cur_w = 128, cur_h = 128, cur_size = 4;

  center_crop_box_downscale_rgba i_dut (.*);

  ccbd_checker i_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("center_crop_box_downscale_rgba: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
    bit ready_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    case (idx)
      ccbd_pkg::REG_SRC_WIDTH:  cur_w = value[7:0];
      ccbd_pkg::REG_SRC_HEIGHT: cur_h = value[7:0];
      ccbd_pkg::REG_DST_SIZE:   cur_size = value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned sz);
    wait_idle();
    write_reg(ccbd_pkg::REG_SRC_WIDTH, 13'(w));
    write_reg(ccbd_pkg::REG_SRC_HEIGHT, 13'(h));
    write_reg(ccbd_pkg::REG_DST_SIZE, 13'(sz));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic push_item(input logic cmd, input logic [6:0] x, input logic [6:0] y,
                           input logic [31:0] rgba, input logic [11:0] px,
                           input logic [11:0] py);
    bit stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    src_x    <= x;
    src_y    <= y;
    {in_alpha, in_blue, in_green, in_red} <= rgba;
    dst_x    <= px;
    dst_y    <= py;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    if (cmd == ccbd_pkg::CMD_LOAD) begin
      loaded[y * SRC_DIM + x] = 1'b1;
      n_loads++;
    end else begin
      n_computes++;
    end
  endtask

  task automatic load_pixel(input int unsigned x, input int unsigned y, input logic [31:0] rgba);
    push_item(ccbd_pkg::CMD_LOAD, 7'(x), 7'(y), rgba, 12'($urandom), 12'($urandom));
  endtask

  // Loads whatever part of the span is still empty, then asks for the pixel.
  task automatic request_pixel(input int unsigned px, input int unsigned py);
    int unsigned side, ox, oy, x0, x1, y0, y1, xs, ys;
    if (cur_w != 0 && cur_h != 0 && cur_w <= SRC_DIM && cur_h <= SRC_DIM &&
        cur_size >= ccbd_pkg::MIN_DST && cur_size <= 4096 && px < cur_size &&
        py < cur_size) begin
      side = (cur_w < cur_h) ? cur_w : cur_h;
      ox = (cur_w - side) / 2;
      oy = (cur_h - side) / 2;
      x0 = (px * side) / cur_size;
      x1 = ((px + 1) * side) / cur_size;
      y0 = (py * side) / cur_size;
      y1 = ((py + 1) * side) / cur_size;
      xs = (x1 > x0) ? x1 - x0 : 1;
      ys = (y1 > y0) ? y1 - y0 : 1;
      for (int unsigned r = oy + y0; r < oy + y0 + ys; r++)
        for (int unsigned c = ox + x0; c < ox + x0 + xs; c++)
          if (!loaded[r * SRC_DIM + c]) load_pixel(c, r, $urandom);
    end
    push_item(ccbd_pkg::CMD_COMPUTE, 7'($urandom), 7'($urandom), $urandom, 12'(px), 12'(py));
  endtask

  initial begin
    int unsigned w, h, sz, mode, n_items, pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset setup, bad setups, coordinate errors, extreme data
    request_pixel(4095, 0);
    request_pixel(0, 4095);
    set_geometry(0, 12, 8);
    request_pixel(1, 1);
    set_geometry(12, 0, 8);
    request_pixel(1, 1);
    set_geometry(255, 12, 8);
    request_pixel(1, 1);
    set_geometry(12, 129, 8);
    request_pixel(1, 1);
    set_geometry(12, 12, 3);
    request_pixel(0, 0);
    set_geometry(12, 12, 8191);
    request_pixel(0, 0);
    set_geometry(12, 12, 4097);
    request_pixel(0, 0);
    set_geometry(5, 9, 4);
    for (int unsigned r = 0; r < 9; r++)
      for (int unsigned c = 0; c < 5; c++)
        load_pixel(c, r, ((r + c) % 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
    request_pixel(0, 0);
    request_pixel(3, 3);
    request_pixel(4, 0);
    set_geometry(128, 128, 4096);
    request_pixel(4095, 4095);
    request_pixel(0, 0);
    set_geometry(128, 1, 4);
    request_pixel(3, 0);
    set_geometry(1, 128, 4);
    request_pixel(0, 3);

    // random phases; idle pattern rotates through the four styles
    for (int phase = 0; phase < 20; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      mode = $urandom_range(9);
      if (phase == 7) begin
        w = 128; h = 128; sz = 8;     // large 16x16 span over the full source
      end else if (mode == 0) begin
        w = $urandom_range(1) ? 0 : $urandom_range(255, 129);
        h = $urandom_range(255);
        sz = $urandom_range(8191);
      end else if (mode == 1) begin
        w = $urandom_range(16); h = $urandom_range(16, 1);
        sz = $urandom_range(1) ? $urandom_range(3) : $urandom_range(8191, 4097);
      end else if (mode <= 3) begin
        w = $urandom_range(128, 1); h = $urandom_range(128, 1);
        sz = $urandom_range(4096, 64);
      end else begin
        w = $urandom_range(16, 1); h = $urandom_range(16, 1);
        sz = $urandom_range(32, 4);
      end
      set_geometry(w, h, sz);
      n_items = (phase == 7) ? 1 : 40;
      for (int i = 0; i < n_items; i++) begin
        pick = $urandom_range(99);
        if (pick < 12)
          load_pixel($urandom_range(127), $urandom_range(127), $urandom);
        else if (pick < 20 || cur_size == 0)
          request_pixel($urandom_range(4095), $urandom_range(4095));
        else if (cur_size > 4096)
          request_pixel($urandom_range(4095), $urandom_range(4095));
        else
          request_pixel($urandom_range(cur_size - 1), $urandom_range(cur_size - 1));
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    $display("covered %0d pixel loads and %0d box requests over %0d setups",
             n_loads, n_computes, n_settings);
    if (fail_count == 0)
      $display("center_crop_box_downscale_rgba: match");
    else
      $display("center_crop_box_downscale_rgba: mismatch");
    $finish;
  end

endmodule
